>>> rtl/mafd_pkg.sv
`timescale 1ns / 1ps
package mafd_pkg;

   typedef logic signed [63:0] val_type;

   localparam val_type ILIM = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic [61:0] MAG_LIM = 62'h3FFF_FFFF_FFFF_FFFF;
   localparam int MUL_LAT = 4;

   function automatic val_type sat_add(val_type a, val_type b);
      val_type s;
      s = a + b;
      if (s > ILIM) begin
         return ILIM;
      end
      if (s < -ILIM) begin
         return -ILIM;
      end
      return s;
   endfunction

   function automatic logic [61:0] mag62(val_type v);
      val_type t;
      t = v[63] ? -v : v;
      return t[61:0];
   endfunction

endpackage

>>> rtl/mafd_delay.sv
`timescale 1ns / 1ps
module mafd_delay #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   if (DEPTH == 0) begin : g_none
      assign dout = din;
   end else begin : g_line
      logic [WIDTH-1:0] line_ff [DEPTH];
      always_ff @(posedge clock) begin
         if (adv) begin
            line_ff[0] <= din;
            for (int n = 1; n < DEPTH; n++) begin
               line_ff[n] <= line_ff[n-1];
            end
         end
      end
      assign dout = line_ff[DEPTH-1];
   end
endmodule

>>> rtl/mafd_fmul.sv
`timescale 1ns / 1ps
module mafd_fmul #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              adv,
   input  mafd_pkg::val_type op_a,
   input  mafd_pkg::val_type op_b,
   output mafd_pkg::val_type prod
);
   localparam int SW = 125;
   localparam logic [SW-1:0] RND = SW'(1) << (FRAC_BITS - 1);

   logic [61:0] ma_ff, mb_ff;
   logic neg1_ff, neg2_ff, neg3_ff;
   logic [61:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [SW-1:0] sum_ff;
   logic [62:0] mid;
   logic [SW-FRAC_BITS-1:0] sh;
   logic [61:0] mag_r;
   mafd_pkg::val_type mag_v;
   mafd_pkg::val_type prod_ff;

   always_comb begin
      mid = 63'(pp01_ff) + 63'(pp10_ff);
      sh = sum_ff[SW-1:FRAC_BITS];
      mag_r = (sh > (SW-FRAC_BITS)'(mafd_pkg::MAG_LIM)) ? mafd_pkg::MAG_LIM : sh[61:0];
      mag_v = mafd_pkg::val_type'({2'b00, mag_r});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // magnitudes, split product, rounded sum, clamp and sign
         neg1_ff <= op_a[63] ^ op_b[63];
         ma_ff <= mafd_pkg::mag62(op_a);
         mb_ff <= mafd_pkg::mag62(op_b);
         neg2_ff <= neg1_ff;
         pp00_ff <= ma_ff[30:0] * mb_ff[30:0];
         pp01_ff <= ma_ff[30:0] * mb_ff[61:31];
         pp10_ff <= ma_ff[61:31] * mb_ff[30:0];
         pp11_ff <= ma_ff[61:31] * mb_ff[61:31];
         neg3_ff <= neg2_ff;
         sum_ff <= SW'({pp11_ff, 62'd0}) + SW'({mid, 31'd0}) + SW'(pp00_ff) + RND;
         prod_ff <= neg3_ff ? -mag_v : mag_v;
      end
   end

   assign prod = prod_ff;
endmodule

>>> rtl/mafd_sqrt.sv
`timescale 1ns / 1ps
module mafd_sqrt #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              adv,
   input  mafd_pkg::val_type x,
   output mafd_pkg::val_type root
);
   localparam int NP = (63 + FRAC_BITS) / 2;
   localparam int RW = 2 * NP;
   localparam int REMW = NP + 3;

   logic [RW-1:0]   rad_ff  [NP];
   logic [REMW-1:0] rem_ff  [NP+1];
   logic [NP-1:0]   root_ff [NP+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff[0] <= (x <= 64'sd0) ? '0 : (RW'(x[61:0]) << FRAC_BITS);
         rem_ff[0] <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < NP; k++) begin : g_step
      logic [REMW-1:0] rem2, trial;
      logic ge;
      always_comb begin
         rem2 = {rem_ff[k][REMW-3:0], rad_ff[k][RW-1 -: 2]};
         trial = REMW'({root_ff[k], 2'b01});
         ge = rem2 >= trial;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1] <= ge ? rem2 - trial : rem2;
            root_ff[k+1] <= {root_ff[k][NP-2:0], ge};
         end
      end
      if (k < NP - 1) begin : g_rad
         always_ff @(posedge clock) begin
            if (adv) begin
               rad_ff[k+1] <= rad_ff[k] << 2;
            end
         end
      end
   end

   assign root = mafd_pkg::val_type'({{(64-NP){1'b0}}, root_ff[NP]});
endmodule

>>> rtl/mafd_div.sv
`timescale 1ns / 1ps
module mafd_div #(
   parameter int NUMW = 63,
   parameter int DENW = 3
) (
   input  logic            clock,
   input  logic            adv,
   input  logic [NUMW-1:0] num,
   input  logic [DENW-1:0] den,
   output logic [NUMW-1:0] quo
);
   // quotient bits shift in at the bottom of the numerator word
   logic [NUMW-1:0] num_ff [NUMW+1];
   logic [DENW-1:0] den_ff [NUMW];
   logic [DENW-1:0] rem_ff [NUMW];

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff[0] <= num;
         den_ff[0] <= den;
         rem_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < NUMW; k++) begin : g_step
      logic [DENW:0] rem2, diff;
      logic ge;
      always_comb begin
         rem2 = {rem_ff[k], num_ff[k][NUMW-1]};
         diff = rem2 - {1'b0, den_ff[k]};
         ge = rem2 >= {1'b0, den_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[k+1] <= {num_ff[k][NUMW-2:0], ge};
         end
      end
      if (k < NUMW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               den_ff[k+1] <= den_ff[k];
               rem_ff[k+1] <= ge ? diff[DENW-1:0] : rem2[DENW-1:0];
            end
         end
      end
   end

   assign quo = num_ff[NUMW];
endmodule

>>> rtl/mesh_adaptation_functional_2d.sv
`timescale 1ns / 1ps
// Mesh adaptation functional for one 2-D element, one element per transfer.
// req channel: Jacobian entries, its determinant and the inverse metric,
// each a signed fixed-point word of WORD_BITS with FRAC_BITS fraction bits.
// rsp channel: energy, gradient with respect to J, derivative with respect
// to the determinant and gradient with respect to the metric; tuser carries
// the domain error flag, and when it is set every data field is zero.
// Throughput: one element per cycle, back to back, unless rsp_tready stalls.
// The latency is set by the dependent chain of the metric square root, its
// reciprocal, the product stages and the byte-per-stage divider for the
// divisions by 3 and 6.
// A stalled rsp_tready freezes the whole pipeline and drops req_tready; the
// held result stays on the rsp port until taken. Reset empties the pipeline.
module mesh_adaptation_functional_2d #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // jac_00, jac_01, jac_10, jac_11, jac_det, minv_00, minv_01, minv_10, minv_11
   input  logic [((9*WORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // energy, grad_j_00, grad_j_01, grad_j_10, grad_j_11, grad_det,
   // grad_m_00, grad_m_01, grad_m_10, grad_m_11
   output logic [((10*WORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // domain_error
   output logic rsp_tuser
);
   localparam int OUT_DW = ((10*WORD_BITS+7)/8)*8;
   localparam int ML = mafd_pkg::MUL_LAT;
   localparam int NP = (63 + FRAC_BITS) / 2;
   localparam int SL = NP + 1;
   localparam int RNUMW = ((2*FRAC_BITS > NP) ? 2*FRAC_BITS : NP) + 1;
   localparam int DL = RNUMW + 1;
   localparam int CDN = 8;
   localparam int VL = CDN + 1;

   localparam int T1 = ML + 1;
   localparam int TR = T1 + SL;
   localparam int TA = T1 + ML + 1;
   localparam int TT = T1 + ML + 3;
   localparam int TQ = TR + SL;
   localparam int TS = TR + DL;
   localparam int TRT = TT + SL;
   localparam int T15 = TRT + ML;
   localparam int TD15 = TR + ML;
   localparam int TE2 = TD15 + ML;
   localparam int TK0 = (TE2 > TQ) ? TE2 : TQ;
   localparam int TK = TK0 + ML;
   localparam int TST0 = (TS > T15) ? TS : T15;
   localparam int TST = TST0 + ML;
   localparam int TSR0 = (TS > TRT) ? TS : TRT;
   localparam int TSR = TSR0 + ML;
   localparam int TH = TSR + ML + 1;
   localparam int XT = (TK > TST) ? TK : TST;
   localparam int TU = XT + 2 + VL + 1;
   localparam int TUM = TU + ML;
   localparam int TO = TUM + 1;

   localparam logic [63:0] SQ2_RAW =
      (64'd1518500250 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   localparam mafd_pkg::val_type SQ2 = mafd_pkg::val_type'(SQ2_RAW);
   localparam mafd_pkg::val_type OUT_HI = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam mafd_pkg::val_type OUT_LO = -(64'sd1 <<< (WORD_BITS - 1));

   function automatic logic [WORD_BITS-1:0] give_out(mafd_pkg::val_type v);
      mafd_pkg::val_type c;
      c = v;
      if (v > OUT_HI) begin
         c = OUT_HI;
      end
      if (v < OUT_LO) begin
         c = OUT_LO;
      end
      return c[WORD_BITS-1:0];
   endfunction

   logic adv;
   logic [TO:0] vld_ff;
   logic rsp_tvalid_ff;
   logic [OUT_DW-1:0] rsp_tdata_ff, data_in;
   logic rsp_tuser_ff;

   assign adv = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[TO-1:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[TO];
      end
   end

   // input stage
   mafd_pkg::val_type jv_ff [4];
   mafd_pkg::val_type mv_ff [4];
   mafd_pkg::val_type det_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 4; n++) begin
            jv_ff[n] <= mafd_pkg::val_type'($signed(req_tdata[n*WORD_BITS +: WORD_BITS]));
            mv_ff[n] <= mafd_pkg::val_type'(
               $signed(req_tdata[(n+5)*WORD_BITS +: WORD_BITS]));
         end
         det_ff <= mafd_pkg::val_type'($signed(req_tdata[4*WORD_BITS +: WORD_BITS]));
      end
   end

   // C = J*Minv, P = Minv*J^T, det(Minv)
   mafd_pkg::val_type ca [4], cb [4], pa [4], pb [4];
   mafd_pkg::val_type d0, d1;
   mafd_pkg::val_type cv_ff [4], pv_ff [4];
   mafd_pkg::val_type dm_ff;

   for (genvar g = 0; g < 4; g++) begin : g_p1
      localparam int RI = g / 2;
      localparam int CJ = g % 2;
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_ca (.clock, .adv,
         .op_a(jv_ff[2*RI]), .op_b(mv_ff[CJ]), .prod(ca[g]));
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_cb (.clock, .adv,
         .op_a(jv_ff[2*RI+1]), .op_b(mv_ff[2+CJ]), .prod(cb[g]));
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_pa (.clock, .adv,
         .op_a(mv_ff[2*RI]), .op_b(jv_ff[2*CJ]), .prod(pa[g]));
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_pb (.clock, .adv,
         .op_a(mv_ff[2*RI+1]), .op_b(jv_ff[2*CJ+1]), .prod(pb[g]));
      always_ff @(posedge clock) begin
         if (adv) begin
            cv_ff[g] <= mafd_pkg::sat_add(ca[g], cb[g]);
            pv_ff[g] <= mafd_pkg::sat_add(pa[g], pb[g]);
         end
      end
   end

   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_d0 (.clock, .adv,
      .op_a(mv_ff[0]), .op_b(mv_ff[3]), .prod(d0));
   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_d1 (.clock, .adv,
      .op_a(mv_ff[1]), .op_b(mv_ff[2]), .prod(d1));

   always_ff @(posedge clock) begin
      if (adv) begin
         dm_ff <= mafd_pkg::sat_add(d0, -d1);
      end
   end

   logic [319:0] jd_flat;
   mafd_pkg::val_type jt [4];
   mafd_pkg::val_type det_t1;
   mafd_delay #(.WIDTH(320), .DEPTH(T1)) u_jdly (.clock, .adv,
      .din({jv_ff[3], jv_ff[2], jv_ff[1], jv_ff[0], det_ff}), .dout(jd_flat));
   assign det_t1 = jd_flat[63:0];

   logic flag_t1, flag_o;
   assign flag_t1 = det_t1[63] | (dm_ff <= 64'sd0);
   mafd_delay #(.WIDTH(1), .DEPTH(TO - T1)) u_fdly (.clock, .adv,
      .din(flag_t1), .dout(flag_o));

   // A = C^T*C and the trace
   mafd_pkg::val_type aa [4], ab [4], tp [4];
   mafd_pkg::val_type av_ff [4];
   mafd_pkg::val_type t01_ff, t012_ff, tp2_ff, tp3a_ff, tp3b_ff, tr_ff, tr_s;

   for (genvar g = 0; g < 4; g++) begin : g_p2
      localparam int RI = g / 2;
      localparam int CJ = g % 2;
      assign jt[g] = jd_flat[64*(g+1) +: 64];
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_aa (.clock, .adv,
         .op_a(cv_ff[RI]), .op_b(cv_ff[CJ]), .prod(aa[g]));
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_ab (.clock, .adv,
         .op_a(cv_ff[2+RI]), .op_b(cv_ff[2+CJ]), .prod(ab[g]));
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_tp (.clock, .adv,
         .op_a(cv_ff[g]), .op_b(jt[g]), .prod(tp[g]));
      always_ff @(posedge clock) begin
         if (adv) begin
            av_ff[g] <= mafd_pkg::sat_add(aa[g], ab[g]);
         end
      end
   end

   assign tr_s = mafd_pkg::sat_add(t012_ff, tp3b_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         t01_ff <= mafd_pkg::sat_add(tp[0], tp[1]);
         tp2_ff <= tp[2];
         tp3a_ff <= tp[3];
         t012_ff <= mafd_pkg::sat_add(t01_ff, tp2_ff);
         tp3b_ff <= tp3a_ff;
         tr_ff <= (tr_s < 64'sd0) ? 64'sd0 : tr_s;
      end
   end

   // roots and reciprocal
   mafd_pkg::val_type r_v, rd_v, q_v, rt_v, s_v;
   logic [RNUMW-1:0] rc_num, rc_q;

   mafd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sr (.clock, .adv, .x(dm_ff), .root(r_v));
   mafd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sd (.clock, .adv, .x(det_t1), .root(rd_v));
   mafd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sq (.clock, .adv, .x(r_v), .root(q_v));
   mafd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_st (.clock, .adv, .x(tr_ff), .root(rt_v));

   assign rc_num = (RNUMW'(1) << (2*FRAC_BITS)) + RNUMW'(r_v[NP-1:1]);
   mafd_div #(.NUMW(RNUMW), .DENW(NP)) u_rc (.clock, .adv,
      .num(rc_num), .den(r_v[NP-1:0]), .quo(rc_q));
   assign s_v = mafd_pkg::val_type'({{(64-RNUMW){1'b0}}, rc_q});

   // tr^1.5, det^1.5 and the sqrt2 terms
   mafd_pkg::val_type tr_d, det_d, t15_v, d15_v, e1_v, e2_v;
   mafd_delay #(.WIDTH(64), .DEPTH(SL)) u_trdly (.clock, .adv, .din(tr_ff), .dout(tr_d));
   mafd_delay #(.WIDTH(64), .DEPTH(SL)) u_ddly (.clock, .adv, .din(det_t1), .dout(det_d));
   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_t15 (.clock, .adv,
      .op_a(tr_d), .op_b(rt_v), .prod(t15_v));
   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_d15 (.clock, .adv,
      .op_a(det_d), .op_b(rd_v), .prod(d15_v));
   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_e1 (.clock, .adv,
      .op_a(SQ2), .op_b(rd_v), .prod(e1_v));
   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_e2 (.clock, .adv,
      .op_a(SQ2), .op_b(d15_v), .prod(e2_v));

   mafd_pkg::val_type qk, e1k, e2k, k_v, gd_v;
   mafd_delay #(.WIDTH(64), .DEPTH(TK0 - TQ)) u_qdly (.clock, .adv, .din(q_v), .dout(qk));
   mafd_delay #(.WIDTH(64), .DEPTH(TK0 - TD15)) u_e1dly (.clock, .adv,
      .din(e1_v), .dout(e1k));
   mafd_delay #(.WIDTH(64), .DEPTH(TK0 - TE2)) u_e2dly (.clock, .adv,
      .din(e2_v), .dout(e2k));
   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_k (.clock, .adv, .op_a(e2k), .op_b(qk), .prod(k_v));
   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_gd (.clock, .adv, .op_a(e1k), .op_b(qk), .prod(gd_v));

   // st = s*t15, sr = s*rt
   mafd_pkg::val_type s_st, t15_st, s_sr, rt_sr, st_v, sr_v;
   mafd_delay #(.WIDTH(64), .DEPTH(TST0 - TS)) u_s1dly (.clock, .adv,
      .din(s_v), .dout(s_st));
   mafd_delay #(.WIDTH(64), .DEPTH(TST0 - T15)) u_t15dly (.clock, .adv,
      .din(t15_v), .dout(t15_st));
   mafd_delay #(.WIDTH(64), .DEPTH(TSR0 - TS)) u_s2dly (.clock, .adv,
      .din(s_v), .dout(s_sr));
   mafd_delay #(.WIDTH(64), .DEPTH(TSR0 - TRT)) u_rtdly (.clock, .adv,
      .din(rt_v), .dout(rt_sr));
   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_stm (.clock, .adv,
      .op_a(s_st), .op_b(t15_st), .prod(st_v));
   mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_srm (.clock, .adv,
      .op_a(s_sr), .op_b(rt_sr), .prod(sr_v));

   // sr*P and -(sr*A)/2
   logic [255:0] pd_flat, ad_flat, md_flat, hd_flat;
   mafd_pkg::val_type gj_v [4], h_v [4], um_v [4];
   mafd_pkg::val_type hn_ff [4], gm_ff [4], u_ff, e_ff;
   logic [255:0] gj_flat, gjo_flat;
   mafd_delay #(.WIDTH(256), .DEPTH(TSR - T1)) u_pdly (.clock, .adv,
      .din({pv_ff[3], pv_ff[2], pv_ff[1], pv_ff[0]}), .dout(pd_flat));
   mafd_delay #(.WIDTH(256), .DEPTH(TSR - TA)) u_adly (.clock, .adv,
      .din({av_ff[3], av_ff[2], av_ff[1], av_ff[0]}), .dout(ad_flat));
   mafd_delay #(.WIDTH(256), .DEPTH(TU)) u_mdly (.clock, .adv,
      .din({mv_ff[3], mv_ff[2], mv_ff[1], mv_ff[0]}), .dout(md_flat));
   mafd_delay #(.WIDTH(256), .DEPTH(TUM - TH)) u_hdly (.clock, .adv,
      .din({hn_ff[3], hn_ff[2], hn_ff[1], hn_ff[0]}), .dout(hd_flat));
   mafd_delay #(.WIDTH(256), .DEPTH(TO - TSR - ML)) u_gjdly (.clock, .adv,
      .din(gj_flat), .dout(gjo_flat));

   for (genvar g = 0; g < 4; g++) begin : g_p3
      logic [62:0] half;
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_gj (.clock, .adv,
         .op_a(sr_v), .op_b(pd_flat[64*g +: 64]), .prod(gj_v[g]));
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_h (.clock, .adv,
         .op_a(sr_v), .op_b(ad_flat[64*g +: 64]), .prod(h_v[g]));
      mafd_fmul #(.FRAC_BITS(FRAC_BITS)) u_um (.clock, .adv,
         .op_a(u_ff), .op_b(md_flat[64*g +: 64]), .prod(um_v[g]));
      assign gj_flat[64*g +: 64] = gj_v[g];
      assign half = (63'(mafd_pkg::mag62(h_v[g])) + 63'd1) >> 1;
      always_ff @(posedge clock) begin
         if (adv) begin
            hn_ff[g] <= h_v[g][63] ? mafd_pkg::val_type'({1'b0, half})
                                   : -mafd_pkg::val_type'({1'b0, half});
            gm_ff[g] <= mafd_pkg::sat_add(hd_flat[64*g +: 64], um_v[g]);
         end
      end
   end

   // energy and u through the rounding dividers
   mafd_pkg::val_type k_x, st_x, gd_o, e_o;
   mafd_pkg::val_type dif_ff, kk_ff, st1_ff, sm_ff, dif2_ff;
   logic [62:0] dif_r, sm_r;
   logic [63:0] dvn [2], dvq [2];
   logic [1:0] sg_d;
   mafd_delay #(.WIDTH(64), .DEPTH(XT - TK)) u_kdly (.clock, .adv, .din(k_v), .dout(k_x));
   mafd_delay #(.WIDTH(64), .DEPTH(XT - TST)) u_stdly (.clock, .adv,
      .din(st_v), .dout(st_x));
   mafd_delay #(.WIDTH(64), .DEPTH(TO - TK)) u_gddly (.clock, .adv,
      .din(gd_v), .dout(gd_o));

   always_ff @(posedge clock) begin
      if (adv) begin
         dif_ff <= mafd_pkg::sat_add(st_x, -k_x);
         kk_ff <= mafd_pkg::sat_add(k_x, k_x);
         st1_ff <= st_x;
         sm_ff <= mafd_pkg::sat_add(st1_ff, kk_ff);
         dif2_ff <= dif_ff;
      end
   end

   assign dif_r = 63'(mafd_pkg::mag62(dif2_ff)) + 63'd3;
   assign sm_r = 63'(mafd_pkg::mag62(sm_ff)) + 63'd1;
   // division by 6 as a halving followed by division by 3
   assign dvn[0] = 64'(dif_r) >> 1;
   assign dvn[1] = 64'(sm_r);

   // division by 3, one byte per stage, digit from a reciprocal product
   for (genvar c = 0; c < 2; c++) begin : g_div3
      logic [63:0] dq_ff [CDN+1];
      logic [1:0]  dr_ff [CDN];
      always_ff @(posedge clock) begin
         if (adv) begin
            dq_ff[0] <= dvn[c];
            dr_ff[0] <= 2'd0;
         end
      end
      for (genvar k = 0; k < CDN; k++) begin : g_dig
         logic [9:0] dv;
         logic [18:0] pr;
         logic [7:0] qd;
         always_comb begin
            dv = {dr_ff[k], dq_ff[k][63 -: 8]};
            pr = 19'(dv) * 19'd683;
            qd = 8'(pr >> 11);
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dq_ff[k+1] <= {dq_ff[k][55:0], qd};
            end
         end
         if (k < CDN - 1) begin : g_rem
            always_ff @(posedge clock) begin
               if (adv) begin
                  dr_ff[k+1] <= 2'(dv - 10'(3 * qd));
               end
            end
         end
      end
      assign dvq[c] = dq_ff[CDN];
   end

   mafd_delay #(.WIDTH(2), .DEPTH(VL)) u_sgdly (.clock, .adv,
      .din({sm_ff[63], dif2_ff[63]}), .dout(sg_d));

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff <= sg_d[0] ? -mafd_pkg::val_type'(dvq[0]) : mafd_pkg::val_type'(dvq[0]);
         e_ff <= sg_d[1] ? -mafd_pkg::val_type'(dvq[1]) : mafd_pkg::val_type'(dvq[1]);
      end
   end

   mafd_delay #(.WIDTH(64), .DEPTH(TO - TU)) u_edly (.clock, .adv, .din(e_ff), .dout(e_o));

   // output register
   always_comb begin
      data_in = '0;
      if (!flag_o) begin
         data_in[0 +: WORD_BITS] = give_out(e_o);
         for (int n = 0; n < 4; n++) begin
            data_in[(n+1)*WORD_BITS +: WORD_BITS] = give_out(gjo_flat[64*n +: 64]);
            data_in[(n+6)*WORD_BITS +: WORD_BITS] = give_out(gm_ff[n]);
         end
         data_in[5*WORD_BITS +: WORD_BITS] = give_out(gd_o);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= data_in;
         rsp_tuser_ff <= flag_o;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;
endmodule
